// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the resampler checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define SR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/sr_pkg.sv -----
// ---------------------------------------------------------------------------
// sr_pkg
// Widths, constants and shared types of the systematic resampler.
// ---------------------------------------------------------------------------
package sr_pkg;

    localparam int P_PARTICLES = 64;           // particles per set, 2..64
    localparam int MAX_SLOTS   = 64;

    localparam int W_W   = 16;                 // Q0.16 weight
    localparam int IDX_W = 6;                  // slot / source index
    localparam int CNT_W = 7;                  // count that can hold 64
    localparam int MAP_W = IDX_W + W_W;        // selection entry {src, weight}

    // scaled running sum 2*P*sum(w) and target (2k+1)*65536
    localparam int SUM_W = $clog2(2 * P_PARTICLES * P_PARTICLES) + W_W;
    // total of selected weights, at most P*65535
    localparam int TOT_W = $clog2(P_PARTICLES) + W_W;

    localparam int UNITY    = 65536;
    localparam int DCNT_W   = $clog2(W_W);

    typedef struct packed {
        logic             start;
        logic [W_W-1:0]   num;
        logic [TOT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [W_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- sv/sr_channels_if.sv -----
// ---------------------------------------------------------------------------
// sr_channels_if
// Valid/ready channels of the resampler: weight input and slot output.
// ---------------------------------------------------------------------------
interface sr_in_if;
    logic                   valid;
    logic                   ready;
    logic [sr_pkg::W_W-1:0] particle_weight;
    logic                   final_weight;

    modport source (output valid, output particle_weight, output final_weight,
                    input ready);
    modport sink   (input valid, input particle_weight, input final_weight,
                    output ready);
endinterface

interface sr_out_if;
    logic                     valid;
    logic                     ready;
    logic [sr_pkg::IDX_W-1:0] slot_index;
    logic [sr_pkg::IDX_W-1:0] source_index;
    logic [sr_pkg::W_W-1:0]   new_weight;
    logic                     last_slot;

    modport source (output valid, output slot_index, output source_index,
                    output new_weight, output last_slot, input ready);
    modport sink   (input valid, input slot_index, input source_index,
                    input new_weight, input last_slot, output ready);
endinterface

// ----- sv/systematic_resampler.sv -----
// ---------------------------------------------------------------------------
// systematic_resampler
// Systematic resampling of a particle set with weight renormalization.
// ---------------------------------------------------------------------------
// Usage:
//  - i_in carries one Q0.16 weight per beat in particle order; final_weight
//    marks the last one. Beats past P weights are dropped, but a final mark
//    still starts the run. Missing particles count as weight zero.
//  - Loading accepts one beat per cycle. After the final beat i_in.ready drops
//    until the last slot has moved into the output register.
//  - Walk: each particle passes S_WREAD, S_WACC and S_WFILL, and S_WFILL
//    repeats once for each slot that the particle fills.
//  - Emit: P beats on o_out, slot 0 first, last_slot on slot P-1. Each
//    slot is read from memory in S_SREAD and S_SDATA, then divided by the
//    one-bit-per-cycle divider in 16 steps; a zero total or a saturated
//    weight skips the steps.
//  - o_out is a register: a stalled receiver holds the beat and the block
//    waits with the next slot's quotient until the register frees.
//  - Reset (synchronous, active low) empties the load count and output
//    register; memory contents stay undefined and need no clearing.
// ---------------------------------------------------------------------------
module systematic_resampler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sr_in_if.sink           i_in,
    sr_out_if.source        o_out
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WREAD = 7'b0000010,
        S_WACC  = 7'b0000100,
        S_WFILL = 7'b0001000,
        S_SREAD = 7'b0010000,
        S_SDATA = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

    localparam logic [sr_pkg::CNT_W-1:0] P_CNT  = sr_pkg::CNT_W'(sr_pkg::P_PARTICLES);
    localparam logic [sr_pkg::IDX_W-1:0] P_LAST = sr_pkg::IDX_W'(sr_pkg::P_PARTICLES - 1);
    localparam logic [sr_pkg::SUM_W-1:0] TGT_0  = sr_pkg::SUM_W'(sr_pkg::UNITY);
    localparam logic [sr_pkg::SUM_W-1:0] TGT_STEP = sr_pkg::SUM_W'(2 * sr_pkg::UNITY);
    localparam logic [sr_pkg::SUM_W-1:0] SCALE  = sr_pkg::SUM_W'(2 * sr_pkg::P_PARTICLES);

    // control
    t_state                      r_state, n_state;
    logic [sr_pkg::CNT_W-1:0]    r_count, n_count;
    logic                        r_out_valid, n_out_valid;

    // run payload
    logic [sr_pkg::CNT_W-1:0]    r_n, n_n;           // weights in this set
    logic [sr_pkg::IDX_W-1:0]    r_idx, n_idx;       // particle, then slot
    logic [sr_pkg::SUM_W-1:0]    r_ssum, n_ssum;     // 2P * running sum
    logic [sr_pkg::SUM_W-1:0]    r_target, n_target; // (2k+1) * 65536
    logic [sr_pkg::CNT_W-1:0]    r_filled, n_filled;
    logic [sr_pkg::TOT_W-1:0]    r_total, n_total;
    logic [sr_pkg::W_W-1:0]      r_wi, n_wi;
    logic [sr_pkg::IDX_W-1:0]    r_src, n_src;

    // output register
    logic [sr_pkg::IDX_W-1:0]    r_out_slot, n_out_slot;
    logic [sr_pkg::IDX_W-1:0]    r_out_src, n_out_src;
    logic [sr_pkg::W_W-1:0]      r_out_weight, n_out_weight;
    logic                        r_out_last, n_out_last;

    // memories
    logic                        w_we;
    logic [sr_pkg::W_W-1:0]      w_rdata;
    logic                        m_we;
    logic [sr_pkg::MAP_W-1:0]    m_wdata, m_rdata;

    sr_pkg::t_div_req            div_req;
    sr_pkg::t_div_rsp            div_rsp;

    logic in_acc, out_free, fill_go, idx_loaded, slot_filled;

    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign fill_go     = (r_filled < P_CNT) && (r_target < r_ssum);
    assign idx_loaded  = {1'b0, r_idx} < r_n;
    assign slot_filled = {1'b0, r_idx} < r_filled;

    assign w_we    = in_acc && (r_count < P_CNT);
    assign m_we    = (r_state == S_WFILL) && fill_go;
    assign m_wdata = {r_idx, r_wi};

    sr_ram #(.WIDTH(sr_pkg::W_W), .DEPTH(sr_pkg::MAX_SLOTS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[sr_pkg::IDX_W-1:0]),
        .i_wdata (i_in.particle_weight),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // selection map: {source index, selected weight} per slot
    sr_ram #(.WIDTH(sr_pkg::MAP_W), .DEPTH(sr_pkg::MAX_SLOTS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_filled[sr_pkg::IDX_W-1:0]),
        .i_wdata (m_wdata),
        .i_raddr (r_idx),
        .o_rdata (m_rdata)
    );

    sr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_n          = r_n;
        n_idx        = r_idx;
        n_ssum       = r_ssum;
        n_target     = r_target;
        n_filled     = r_filled;
        n_total      = r_total;
        n_wi         = r_wi;
        n_src        = r_src;
        n_out_slot   = r_out_slot;
        n_out_src    = r_out_src;
        n_out_weight = r_out_weight;
        n_out_last   = r_out_last;
        div_req      = '0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (w_we) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.final_weight) begin
                        n_n      = w_we ? r_count + 1'b1 : r_count;
                        n_count  = '0;
                        n_idx    = '0;
                        n_ssum   = '0;
                        n_target = TGT_0;
                        n_filled = '0;
                        n_total  = '0;
                        n_state  = S_WREAD;
                    end
                end
            end
            S_WREAD: begin
                n_state = S_WACC;    // weight of particle r_idx on its way
            end
            S_WACC: begin
                n_wi    = idx_loaded ? w_rdata : '0;
                n_ssum  = r_ssum + sr_pkg::SUM_W'(idx_loaded ? w_rdata : '0) * SCALE;
                n_state = S_WFILL;
            end
            S_WFILL: begin
                // one slot per cycle while under P slots and the running sum passes the target
                if (fill_go) begin
                    n_filled = r_filled + 1'b1;
                    n_total  = r_total + sr_pkg::TOT_W'(r_wi);
                    n_target = r_target + TGT_STEP;
                end else if (r_idx == P_LAST) begin
                    n_idx   = '0;
                    n_state = S_SREAD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WREAD;
                end
            end
            S_SREAD: begin
                n_state = S_SDATA;
            end
            S_SDATA: begin
                // unfilled slots keep their own index and own weight
                div_req.start = 1'b1;
                div_req.den   = r_total;
                if (slot_filled) begin
                    n_src       = m_rdata[sr_pkg::MAP_W-1:sr_pkg::W_W];
                    div_req.num = m_rdata[sr_pkg::W_W-1:0];
                end else begin
                    n_src       = r_idx;
                    div_req.num = idx_loaded ? w_rdata : '0;
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_idx;
                    n_out_src    = r_src;
                    n_out_weight = div_rsp.quot;
                    n_out_last   = (r_idx == P_LAST);
                    if (r_idx == P_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_idx        <= n_idx;
        r_ssum       <= n_ssum;
        r_target     <= n_target;
        r_filled     <= n_filled;
        r_total      <= n_total;
        r_wi         <= n_wi;
        r_src        <= n_src;
        r_out_slot   <= n_out_slot;
        r_out_src    <= n_out_src;
        r_out_weight <= n_out_weight;
        r_out_last   <= n_out_last;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.slot_index   = r_out_slot;
    assign o_out.source_index = r_out_src;
    assign o_out.new_weight   = r_out_weight;
    assign o_out.last_slot    = r_out_last;

endmodule

// ----- sv/sr_ram.sv -----
// ---------------------------------------------------------------------------
// sr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sr_div.sv -----
// ---------------------------------------------------------------------------
// sr_div
// Bit-serial restoring divider: quot = num*65536/den saturated, 0 if den=0.
// ---------------------------------------------------------------------------
module sr_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sr_pkg::t_div_req i_req,
    output sr_pkg::t_div_rsp o_rsp
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [sr_pkg::DCNT_W-1:0]   r_cnt, n_cnt;
    logic [sr_pkg::TOT_W-1:0]    r_rem, n_rem;
    logic [sr_pkg::TOT_W-1:0]    r_den, n_den;
    logic [sr_pkg::W_W-1:0]      r_quot, n_quot;

    logic [sr_pkg::TOT_W:0]      shifted;
    logic [sr_pkg::TOT_W:0]      diff;
    logic                        fits;

    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_req.start) begin
            n_den = i_req.den;
            n_rem = sr_pkg::TOT_W'(i_req.num);
            n_cnt = sr_pkg::DCNT_W'(sr_pkg::W_W - 1);
            if (i_req.den == '0) begin
                n_quot = '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (sr_pkg::TOT_W'(i_req.num) >= i_req.den) begin
                n_quot = '1;    // quotient would reach 1.0
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_quot = '0;
                n_busy = 1'b1;
                n_done = 1'b0;
            end
        end else if (r_busy) begin
            n_quot = {r_quot[sr_pkg::W_W-2:0], fits};
            n_rem  = fits ? diff[sr_pkg::TOT_W-1:0] : shifted[sr_pkg::TOT_W-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- sv/sr_checker.sv -----
// ---------------------------------------------------------------------------
// sr_checker
// Port-level checks of the resampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sr_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_final,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [sr_pkg::IDX_W-1:0] i_out_slot,
    input logic [sr_pkg::IDX_W-1:0] i_out_src,
    input logic [sr_pkg::W_W-1:0]   i_out_weight,
    input logic                     i_out_last
);

    // stalled beat holds
    `SR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_slot) && $stable(i_out_src)
            && $stable(i_out_weight) && $stable(i_out_last))

    // last flag only on the final slot
    `SR_ASSERT_NOW(a_last_slot, i_clk, i_rst_n, i_out_valid && i_out_last,
        i_out_slot == sr_pkg::IDX_W'(sr_pkg::P_PARTICLES - 1))

    // loading resumes only once every slot but the last is taken
    `SR_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_in_ready && i_out_valid, i_out_last)

    // a weight without final mark keeps the block loading
    `SR_ASSERT_NEXT(a_keep_loading, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_final,
        i_in_ready)

endmodule

bind systematic_resampler sr_checker u_sr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_final   (i_in.final_weight),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_slot   (o_out.slot_index),
    .i_out_src    (o_out.source_index),
    .i_out_weight (o_out.new_weight),
    .i_out_last   (o_out.last_slot)
);
